// ===== design/yca_pkg.sv =====
// ----------------------------------------------------------------------------
// yca_pkg
// Shared types, register codes, reset values and helpers of the YIQ color
// adjust block.
// ----------------------------------------------------------------------------
package yca_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned NORM_W   = 13;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_GAIN    = 3'd0,
        REG_BRIGHTNESS   = 3'd1,
        REG_COEF_RED_I   = 3'd2,
        REG_COEF_RED_Q   = 3'd3,
        REG_COEF_GREEN_I = 3'd4,
        REG_COEF_GREEN_Q = 3'd5,
        REG_COEF_BLUE_I  = 3'd6,
        REG_COEF_BLUE_Q  = 3'd7
    } cfg_reg_t;

    // reset values
    localparam logic [14:0]        LUMA_GAIN_RST    = 15'd16384;
    localparam logic signed [12:0] BRIGHTNESS_RST   = 13'sd0;
    localparam logic signed [15:0] COEF_RED_I_RST   = 16'sd3916;
    localparam logic signed [15:0] COEF_RED_Q_RST   = 16'sd2544;
    localparam logic signed [15:0] COEF_GREEN_I_RST = -16'sd1114;
    localparam logic signed [15:0] COEF_GREEN_Q_RST = -16'sd2650;
    localparam logic signed [15:0] COEF_BLUE_I_RST  = -16'sd4526;
    localparam logic signed [15:0] COEF_BLUE_Q_RST  = 16'sd6971;

    // ntsc rgb to yiq weights, q0.12
    localparam logic signed [25:0] KY_R = 26'sd1225;
    localparam logic signed [25:0] KY_G = 26'sd2404;
    localparam logic signed [25:0] KY_B = 26'sd467;
    localparam logic signed [25:0] KI_R = 26'sd2441;
    localparam logic signed [25:0] KI_G = 26'sd1126;
    localparam logic signed [25:0] KI_B = 26'sd1315;
    localparam logic signed [25:0] KQ_R = 26'sd868;
    localparam logic signed [25:0] KQ_G = 26'sd2142;
    localparam logic signed [25:0] KQ_B = 26'sd1274;

    localparam logic [12:0] FULL_SCALE = 13'd4096;

    typedef struct packed {
        logic [14:0]        luma_gain;
        logic signed [12:0] brightness_offset;
        logic signed [15:0] coef_red_i;
        logic signed [15:0] coef_red_q;
        logic signed [15:0] coef_green_i;
        logic signed [15:0] coef_green_q;
        logic signed [15:0] coef_blue_i;
        logic signed [15:0] coef_blue_q;
    } cfg_t;

    typedef struct packed {
        logic [12:0]        y;
        logic signed [12:0] i;
        logic signed [12:0] q;
    } yiq_t;

    // adjusted luma and the three rounded chroma terms
    typedef struct packed {
        logic signed [16:0] y;
        logic signed [17:0] cr;
        logic signed [17:0] cg;
        logic signed [17:0] cb;
    } adj_t;

    // round(x * 4096 / 255) = 16x + floor((16x + 127) / 255)
    function automatic logic [NORM_W-1:0] norm_channel(input logic [PIX_W-1:0] x);
        logic [12:0] v;
        logic [12:0] q;
        v = {1'b0, x, 4'b0000} + 13'd127;
        // divide by 255 for v below 4335
        q = (v + {8'b0, v[12:8]} + 13'd1) >> 8;
        return {1'b0, x, 4'b0000} + q;
    endfunction

endpackage

// ===== design/yca_cfg.sv =====
// ----------------------------------------------------------------------------
// yca_cfg
// Configuration register file: contrast gain, brightness and the six
// chroma weights of the yiq to rgb matrix.
// ----------------------------------------------------------------------------
module yca_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [yca_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [yca_pkg::CFG_W-1:0]         wr_data,
    output yca_pkg::cfg_t                     cfg
);

    yca_pkg::cfg_t cfg_reg;
    yca_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (yca_pkg::cfg_reg_t'(wr_index))
                yca_pkg::REG_LUMA_GAIN:    cfg_next.luma_gain         = wr_data[14:0];
                yca_pkg::REG_BRIGHTNESS:   cfg_next.brightness_offset = wr_data[12:0];
                yca_pkg::REG_COEF_RED_I:   cfg_next.coef_red_i        = wr_data;
                yca_pkg::REG_COEF_RED_Q:   cfg_next.coef_red_q        = wr_data;
                yca_pkg::REG_COEF_GREEN_I: cfg_next.coef_green_i      = wr_data;
                yca_pkg::REG_COEF_GREEN_Q: cfg_next.coef_green_q      = wr_data;
                yca_pkg::REG_COEF_BLUE_I:  cfg_next.coef_blue_i       = wr_data;
                yca_pkg::REG_COEF_BLUE_Q:  cfg_next.coef_blue_q       = wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.luma_gain         <= yca_pkg::LUMA_GAIN_RST;
            cfg_reg.brightness_offset <= yca_pkg::BRIGHTNESS_RST;
            cfg_reg.coef_red_i        <= yca_pkg::COEF_RED_I_RST;
            cfg_reg.coef_red_q        <= yca_pkg::COEF_RED_Q_RST;
            cfg_reg.coef_green_i      <= yca_pkg::COEF_GREEN_I_RST;
            cfg_reg.coef_green_q      <= yca_pkg::COEF_GREEN_Q_RST;
            cfg_reg.coef_blue_i       <= yca_pkg::COEF_BLUE_I_RST;
            cfg_reg.coef_blue_q       <= yca_pkg::COEF_BLUE_Q_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/yca_rgb2yiq.sv =====
// ----------------------------------------------------------------------------
// yca_rgb2yiq
// Two pipeline stages: channel normalization to q0.12, then the fixed
// ntsc matrix with rounding to yiq.
// ----------------------------------------------------------------------------
module yca_rgb2yiq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic [yca_pkg::PIX_W-1:0]     red,
    input  logic [yca_pkg::PIX_W-1:0]     green,
    input  logic [yca_pkg::PIX_W-1:0]     blue,
    output logic                          valid_out,
    output yca_pkg::yiq_t                 yiq
);

    logic                          s1_valid_reg;
    logic [yca_pkg::NORM_W-1:0]    nr_reg;
    logic [yca_pkg::NORM_W-1:0]    ng_reg;
    logic [yca_pkg::NORM_W-1:0]    nb_reg;

    logic                          s2_valid_reg;
    yca_pkg::yiq_t                 yiq_reg;
    yca_pkg::yiq_t                 yiq_next;

    logic signed [25:0]            sr;
    logic signed [25:0]            sg;
    logic signed [25:0]            sb;
    logic signed [25:0]            y_sum;
    logic signed [25:0]            i_sum;
    logic signed [25:0]            q_sum;

    always_comb
    begin
        sr    = $signed({13'b0, nr_reg});
        sg    = $signed({13'b0, ng_reg});
        sb    = $signed({13'b0, nb_reg});
        y_sum = yca_pkg::KY_R * sr + yca_pkg::KY_G * sg + yca_pkg::KY_B * sb + 26'sd2048;
        i_sum = yca_pkg::KI_R * sr - yca_pkg::KI_G * sg - yca_pkg::KI_B * sb + 26'sd2048;
        q_sum = yca_pkg::KQ_R * sr - yca_pkg::KQ_G * sg + yca_pkg::KQ_B * sb + 26'sd2048;
        // round half up: bias added above, then floor shift
        yiq_next.y = y_sum[24:12];
        yiq_next.i = i_sum[24:12];
        yiq_next.q = q_sum[24:12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= valid_in;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            nr_reg <= yca_pkg::norm_channel(red);
            ng_reg <= yca_pkg::norm_channel(green);
            nb_reg <= yca_pkg::norm_channel(blue);
        end
        if (s1_valid_reg)
        begin
            yiq_reg <= yiq_next;
        end
    end

    assign valid_out = s2_valid_reg;
    assign yiq       = yiq_reg;

endmodule

// ===== design/yca_adjust.sv =====
// ----------------------------------------------------------------------------
// yca_adjust
// Two pipeline stages: contrast gain and chroma weight products, then
// rounding, brightness offset and the sum of the chroma terms.
// ----------------------------------------------------------------------------
module yca_adjust (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  yca_pkg::yiq_t     yiq,
    input  yca_pkg::cfg_t     cfg,
    output logic              valid_out,
    output yca_pkg::adj_t     adj
);

    logic                  s3_valid_reg;
    logic [27:0]           ymul_reg;
    logic signed [28:0]    p_ri_reg;
    logic signed [28:0]    p_rq_reg;
    logic signed [28:0]    p_gi_reg;
    logic signed [28:0]    p_gq_reg;
    logic signed [28:0]    p_bi_reg;
    logic signed [28:0]    p_bq_reg;

    logic                  s4_valid_reg;
    yca_pkg::adj_t         adj_reg;
    yca_pkg::adj_t         adj_next;

    logic [28:0]           ymul_rnd;
    logic [14:0]           y_scaled;

    function automatic logic signed [17:0] chroma_term(input logic signed [28:0] pi,
                                                       input logic signed [28:0] pq);
        logic signed [29:0] s;
        s = {pi[28], pi} + {pq[28], pq} + 30'sd2048;
        return s[29:12];
    endfunction

    always_comb
    begin
        ymul_rnd    = {1'b0, ymul_reg} + 29'd8192;
        y_scaled    = ymul_rnd[28:14];
        adj_next.y  = $signed({2'b0, y_scaled})
                    + $signed({{4{cfg.brightness_offset[12]}}, cfg.brightness_offset});
        adj_next.cr = chroma_term(p_ri_reg, p_rq_reg);
        adj_next.cg = chroma_term(p_gi_reg, p_gq_reg);
        adj_next.cb = chroma_term(p_bi_reg, p_bq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= valid_in;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            ymul_reg <= 28'(yiq.y * cfg.luma_gain);
            p_ri_reg <= 29'(cfg.coef_red_i * yiq.i);
            p_rq_reg <= 29'(cfg.coef_red_q * yiq.q);
            p_gi_reg <= 29'(cfg.coef_green_i * yiq.i);
            p_gq_reg <= 29'(cfg.coef_green_q * yiq.q);
            p_bi_reg <= 29'(cfg.coef_blue_i * yiq.i);
            p_bq_reg <= 29'(cfg.coef_blue_q * yiq.q);
        end
        if (s3_valid_reg)
        begin
            adj_reg <= adj_next;
        end
    end

    assign valid_out = s4_valid_reg;
    assign adj       = adj_reg;

endmodule

// ===== design/yca_yiq2rgb.sv =====
// ----------------------------------------------------------------------------
// yca_yiq2rgb
// Output stage: luma plus chroma per channel, clamp to full scale and
// rescale to 0..255 with rounding.
// ----------------------------------------------------------------------------
module yca_yiq2rgb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  yca_pkg::adj_t                 adj,
    output logic                          valid_out,
    output logic [yca_pkg::PIX_W-1:0]     red,
    output logic [yca_pkg::PIX_W-1:0]     green,
    output logic [yca_pkg::PIX_W-1:0]     blue
);

    logic                          s5_valid_reg;
    logic [yca_pkg::PIX_W-1:0]     red_reg;
    logic [yca_pkg::PIX_W-1:0]     green_reg;
    logic [yca_pkg::PIX_W-1:0]     blue_reg;

    function automatic logic [yca_pkg::PIX_W-1:0] to_byte(input logic signed [16:0] y,
                                                          input logic signed [17:0] c);
        logic signed [18:0] s;
        logic [12:0]        cl;
        logic [20:0]        sc;
        s = {{2{y[16]}}, y} + {c[17], c};
        if (s[18])
        begin
            cl = 13'd0;
        end
        else if (s > $signed({6'b0, yca_pkg::FULL_SCALE}))
        begin
            cl = yca_pkg::FULL_SCALE;
        end
        else
        begin
            cl = s[12:0];
        end
        // cl * 255 rounded back to eight bits
        sc = {cl, 8'b0} - {8'b0, cl} + 21'd2048;
        return sc[19:12];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s5_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            red_reg   <= to_byte(adj.y, adj.cr);
            green_reg <= to_byte(adj.y, adj.cg);
            blue_reg  <= to_byte(adj.y, adj.cb);
        end
    end

    assign valid_out = s5_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== design/yiq_color_adjust.sv =====
// ----------------------------------------------------------------------------
// yiq_color_adjust
// Brightness, contrast, hue and saturation adjustment of rgb pixels in yiq
// space, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel is taken on red_in/green_in/blue_in at each clock edge where
//   start is high and busy is low. busy stays low, so a pixel may enter on
//   every cycle.
//   The adjusted pixel appears on red_out/green_out/blue_out with done high
//   for exactly one cycle; the transfer completes at the edge ending that
//   cycle. The receiver cannot hold results off, and none is needed.
//   A pixel accepted at an edge passes through five pipeline registers
//   (normalize, matrix, products, round and sum, clamp and rescale) before
//   it is shown. Throughput: one pixel per cycle.
//   Registers are written through wr_en/wr_index/wr_data at any edge where
//   wr_en is high; write them only while no pixel is in flight.
//   Reset clears the pipeline valid bits and loads the default gain,
//   zero brightness and the unrotated chroma weights.
// ----------------------------------------------------------------------------
module yiq_color_adjust (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [yca_pkg::PIX_W-1:0]         red_in,
    input  logic [yca_pkg::PIX_W-1:0]         green_in,
    input  logic [yca_pkg::PIX_W-1:0]         blue_in,
    output logic                              done,
    output logic [yca_pkg::PIX_W-1:0]         red_out,
    output logic [yca_pkg::PIX_W-1:0]         green_out,
    output logic [yca_pkg::PIX_W-1:0]         blue_out,
    input  logic                              wr_en,
    input  logic [yca_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [yca_pkg::CFG_W-1:0]         wr_data
);

    yca_pkg::cfg_t  cfg;
    yca_pkg::yiq_t  yiq;
    yca_pkg::adj_t  adj;
    logic           accept;
    logic           yiq_valid;
    logic           adj_valid;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    yca_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    yca_rgb2yiq u_rgb2yiq (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (accept),
        .red       (red_in),
        .green     (green_in),
        .blue      (blue_in),
        .valid_out (yiq_valid),
        .yiq       (yiq)
    );

    yca_adjust u_adjust (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (yiq_valid),
        .yiq       (yiq),
        .cfg       (cfg),
        .valid_out (adj_valid),
        .adj       (adj)
    );

    yca_yiq2rgb u_yiq2rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (adj_valid),
        .adj       (adj),
        .valid_out (done),
        .red       (red_out),
        .green     (green_out),
        .blue      (blue_out)
    );

endmodule

// ===== design/yca_checker.sv =====
// ----------------------------------------------------------------------------
// yca_checker
// Port-level checks of the color adjust pipeline: latency, no spurious
// results and repeatable outputs for repeated pixels.
// ----------------------------------------------------------------------------
module yca_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic [yca_pkg::PIX_W-1:0]         red_in,
    input logic [yca_pkg::PIX_W-1:0]         green_in,
    input logic [yca_pkg::PIX_W-1:0]         blue_in,
    input logic                              done,
    input logic [yca_pkg::PIX_W-1:0]         red_out,
    input logic [yca_pkg::PIX_W-1:0]         green_out,
    input logic [yca_pkg::PIX_W-1:0]         blue_out,
    input logic                              wr_en
);

    // the pipeline never refuses a pixel
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every transfer in gives a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result missing after accepted pixel");

    // no result without a matching accepted pixel
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 5))
        else $error("result without accepted pixel");

    // same pixel twice in a row with no register write gives the same result
    a_repeatable: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done)
         && $past(red_in, 5) == $past(red_in, 6)
         && $past(green_in, 5) == $past(green_in, 6)
         && $past(blue_in, 5) == $past(blue_in, 6)
         && !$past(wr_en, 1) && !$past(wr_en, 2) && !$past(wr_en, 3)
         && !$past(wr_en, 4) && !$past(wr_en, 5) && !$past(wr_en, 6))
        |-> (red_out == $past(red_out) && green_out == $past(green_out)
             && blue_out == $past(blue_out)))
        else $error("repeated pixel gave a different result");

endmodule

bind yiq_color_adjust yca_checker u_yca_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of yiq_color_adjust. Pixels go in over the start
// handshake with random gaps. A scoreboard keeps its own copy of the
// registers and computes the expected adjusted pixel for every transfer.
// Results are compared in order. The run walks through several register
// settings, including the extremes and raw bit patterns.
// ----------------------------------------------------------------------------
module tb;
    import yca_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 50000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    class yca_scoreboard;
        cfg_t        shadow;
        pixel_t      adjusted_q[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            shadow.luma_gain         = LUMA_GAIN_RST;
            shadow.brightness_offset = BRIGHTNESS_RST;
            shadow.coef_red_i        = COEF_RED_I_RST;
            shadow.coef_red_q        = COEF_RED_Q_RST;
            shadow.coef_green_i      = COEF_GREEN_I_RST;
            shadow.coef_green_q      = COEF_GREEN_Q_RST;
            shadow.coef_blue_i       = COEF_BLUE_I_RST;
            shadow.coef_blue_q       = COEF_BLUE_Q_RST;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_LUMA_GAIN:    shadow.luma_gain         = data[14:0];
                REG_BRIGHTNESS:   shadow.brightness_offset = data[12:0];
                REG_COEF_RED_I:   shadow.coef_red_i        = data;
                REG_COEF_RED_Q:   shadow.coef_red_q        = data;
                REG_COEF_GREEN_I: shadow.coef_green_i      = data;
                REG_COEF_GREEN_Q: shadow.coef_green_q      = data;
                REG_COEF_BLUE_I:  shadow.coef_blue_i       = data;
                REG_COEF_BLUE_Q:  shadow.coef_blue_q       = data;
                default: ;
            endcase
        endfunction

        // round half up: floor((v + 2^(sh-1)) / 2^sh)
        function longint round_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        function longint to_q12(logic [PIX_W-1:0] x);
            return (longint'(x) * 4096 + 127) / 255;
        endfunction

        function logic [PIX_W-1:0] rebuild_channel(longint y, longint i, longint q,
                                                   logic signed [15:0] wi,
                                                   logic signed [15:0] wq);
            longint c;
            c = y + round_shift(longint'(wi) * i + longint'(wq) * q, 12);
            if (c < 0)
                c = 0;
            if (c > 4096)
                c = 4096;
            return PIX_W'((c * 255 + 2048) >>> 12);
        endfunction

        function pixel_t adjust_pixel(pixel_t src);
            longint nr;
            longint ng;
            longint nb;
            longint y;
            longint i;
            longint q;
            pixel_t res;
            nr = to_q12(src.red);
            ng = to_q12(src.green);
            nb = to_q12(src.blue);
            y  = round_shift(1225 * nr + 2404 * ng + 467 * nb, 12);
            i  = round_shift(2441 * nr - 1126 * ng - 1315 * nb, 12);
            q  = round_shift(868 * nr - 2142 * ng + 1274 * nb, 12);
            y  = round_shift(y * longint'(shadow.luma_gain), 14)
               + longint'($signed(shadow.brightness_offset));
            res.red   = rebuild_channel(y, i, q, shadow.coef_red_i, shadow.coef_red_q);
            res.green = rebuild_channel(y, i, q, shadow.coef_green_i, shadow.coef_green_q);
            res.blue  = rebuild_channel(y, i, q, shadow.coef_blue_i, shadow.coef_blue_q);
            return res;
        endfunction

        function void note_pixel(pixel_t src);
            adjusted_q.push_back(adjust_pixel(src));
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (adjusted_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result r=%0d g=%0d b=%0d with no pixel pending",
                             got.red, got.green, got.blue);
                return;
            end
            want = adjusted_q.pop_front();
            checked++;
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch on result %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                             checked, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
            end
        endfunction

        function int unsigned pending();
            return adjusted_q.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [PIX_W-1:0]     red_in;
    logic [PIX_W-1:0]     green_in;
    logic [PIX_W-1:0]     blue_in;
    logic                 done;
    logic [PIX_W-1:0]     red_out;
    logic [PIX_W-1:0]     green_out;
    logic [PIX_W-1:0]     blue_out;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [CFG_W-1:0]     wr_data;

    yca_scoreboard sb;
    int unsigned   cycles;
    int unsigned   reg_writes;
    int unsigned   settings_used;
    int unsigned   burst_left;

    yiq_color_adjust i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .done      (done),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("tb: FAIL");
            $finish;
        end
    end

    // outputs are read in the active region of the edge, before any update
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_pixel('{red: red_out, green: green_out, blue: blue_out});
    end

    // one register transfer, after which wr_en goes low before the task returns
    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_setting(logic [CFG_W-1:0] gain, logic [CFG_W-1:0] bright,
                                logic [CFG_W-1:0] ri, logic [CFG_W-1:0] rq,
                                logic [CFG_W-1:0] gi, logic [CFG_W-1:0] gq,
                                logic [CFG_W-1:0] bi, logic [CFG_W-1:0] bq);
        write_reg(REG_LUMA_GAIN, gain);
        write_reg(REG_BRIGHTNESS, bright);
        write_reg(REG_COEF_RED_I, ri);
        write_reg(REG_COEF_RED_Q, rq);
        write_reg(REG_COEF_GREEN_I, gi);
        write_reg(REG_COEF_GREEN_Q, gq);
        write_reg(REG_COEF_BLUE_I, bi);
        write_reg(REG_COEF_BLUE_Q, bq);
        settings_used++;
    endtask

    // called at a falling edge, returns at a falling edge with start still high
    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b);
        int unsigned gap;
        gap = (burst_left != 0) ? 0 : $urandom_range(0, 3);
        if (burst_left != 0)
            burst_left--;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start    <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_pixel('{red: r, green: g, blue: b});
        @(negedge clk);
    endtask

    // full-range channel with extra weight on the two ends
    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic run_random(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n % 16 == 0)
                burst_left = $urandom_range(0, 1) * 10;
            send_pixel(pick_channel(), pick_channel(), pick_channel());
        end
        start <= 1'b0;
    endtask

    // every pixel yields a result, so an empty queue means an empty pipeline
    task automatic drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_W-1:0] near_default(logic signed [15:0] base);
        return CFG_W'(int'(base) + $urandom_range(0, 4096) - 2048);
    endfunction

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        red_in        = '0;
        green_in      = '0;
        blue_in       = '0;
        wr_en         = 1'b0;
        wr_index      = REG_LUMA_GAIN;
        wr_data       = '0;
        cycles        = 0;
        reg_writes    = 0;
        settings_used = 1;
        burst_left    = 0;
        sb            = new();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: black, white, primaries, secondaries, grays, patterns
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd254, 8'd254, 8'd254);
        send_pixel(8'd127, 8'd128, 8'd129);
        send_pixel(8'h55, 8'hAA, 8'h55);
        send_pixel(8'hAA, 8'h55, 8'hAA);
        send_pixel(8'd0, 8'd255, 8'd128);
        run_random(65);
        drain();

        // zero contrast, mid brightness, no chroma: flat gray
        load_setting(16'd0, 16'd2048, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random(55);
        drain();

        // maximum gain and weights of both signs: saturates both ways
        load_setting(16'h7FFF, 16'hF800, 16'h7FFF, 16'h8000,
                     16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        run_random(55);
        drain();

        // unused upper bits set, brightness beyond +2048, reset weights
        load_setting(16'hC000, 16'hEFFF, COEF_RED_I_RST, COEF_RED_Q_RST,
                     COEF_GREEN_I_RST, COEF_GREEN_Q_RST, COEF_BLUE_I_RST,
                     COEF_BLUE_Q_RST);
        run_random(55);
        drain();

        // brightness at its most negative raw value with full gain
        load_setting(16'h7FFF, 16'h1000, 16'h8000, 16'h8000,
                     16'h8000, 16'h8000, 16'h8000, 16'h8000);
        run_random(55);
        drain();

        // raw bit patterns everywhere
        repeat (2)
        begin
            load_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                         CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                         CFG_W'($urandom), CFG_W'($urandom));
            run_random(55);
            drain();
        end

        // plausible hue and saturation tweaks around the defaults
        load_setting(CFG_W'($urandom_range(8192, 24576)),
                     CFG_W'(int'($urandom_range(0, 4096)) - 2048),
                     near_default(COEF_RED_I_RST), near_default(COEF_RED_Q_RST),
                     near_default(COEF_GREEN_I_RST), near_default(COEF_GREEN_Q_RST),
                     near_default(COEF_BLUE_I_RST), near_default(COEF_BLUE_Q_RST));
        run_random(55);
        drain();

        $display("covered %0d adjusted pixels under %0d register settings (%0d writes)",
                 sb.checked, settings_used, reg_writes);
        $display("%0d mismatches, %0d results never seen", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
